[sv/lph_pkg.sv]
// Shared types and constants for the linear-probing hash table.
// Used by the controller, the datapath and the top level; depends on nothing.
package lph_pkg;

    // Default slot count handed down from the top level.
    localparam int SLOTS_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 2;

    // The home slot is computed eight key bits per cycle, over HASH_STEPS steps.
    localparam int HASH_BITS  = 8;
    localparam int HASH_STEPS = KEY_W / HASH_BITS;
    localparam int HCNT_W     = $clog2(HASH_STEPS);

    // Operation codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Slot marks kept in the mark memory; an empty slot is one whose valid bit is clear.
    localparam logic [MARK_W-1:0] MARK_USED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_step;
        logic commit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_last;
        logic probe_done;
    } t_ctl_sts;

endpackage

[sv/linear_probe_hash_table.sv]
// Top level of the linear-probing hash table: joins controller and datapath.
// Depends on lph_pkg, lph_ctrl and lph_dp.

// An open-addressed key/value table of SLOTS entries. A request is taken at a
// clock edge where start is high and busy is low; it carries an operation
// (insert or update, search, remove), a key and a value. Exactly one result
// comes back per request: o_done is high for a single cycle while o_status
// and o_data_out hold it, and the receiver cannot stall, so it must take the
// result in that cycle. A request is handled in steps, in this order: the
// home slot is computed, key modulo SLOTS, eight key bits per cycle; the
// probe then visits 1 to SLOTS slots, one slot per cycle, from the slot
// memories, whose read is registered; the commit step writes the table, and
// the result shows in the cycle after it. Busy falls in the result cycle, so
// the next request may be accepted at the edge that ends it; no new request
// is taken while one is in progress. An insert of a new key goes into the
// first tombstone passed, else into the empty slot that ended the probe; if
// neither exists the insert is rejected with the table-full status and
// nothing changes. A remove leaves a tombstone. All slots are empty after
// reset, with no clearing pass.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_data_in,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    // The controller sequences load, home-slot computation, probe and commit.
    lph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (ctl_sts),
        .o_cmd   (ctl_cmd),
        .o_busy  (busy)
    );

    // The datapath holds the slot memories and produces the result.
    lph_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctl_cmd),
        .o_sts      (ctl_sts),
        .i_op       (i_cmd),
        .i_key      (i_key),
        .i_data_in  (i_data_in),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data_out (o_data_out)
    );

endmodule

[sv/lph_ctrl.sv]
// Sequencing state machine for the linear-probing hash table.
// Depends on lph_pkg for the state type and the command/status structs.
module lph_ctrl
    import lph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_sts.hash_last) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.probe_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy   = 1'b0;
                o_cmd.load = i_start;
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
            end
            S_PROBE: begin
                o_cmd.probe_step = !i_sts.probe_done;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

[sv/lph_dp.sv]
// Datapath of the linear-probing hash table: request registers, home-slot
// residue unit, probe pointer, slot memories and result registers. Uses lph_pkg.
module lph_dp
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl_cmd            i_cmd,
    output t_ctl_sts            o_sts,
    input  logic [CMD_W-1:0]    i_op,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_data_in,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS - 1);

    // Request registers.
    logic [CMD_W-1:0]  r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_din;

    // Residue unit.
    logic [KEY_W-1:0]  r_kshift;
    logic [IDX_W-1:0]  r_res;
    logic [IDX_W-1:0]  n_res;
    logic [HCNT_W-1:0] r_hcnt;

    // Probe state.
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_rd_pos;
    logic             r_rd_ok;
    logic [CNT_W-1:0] r_cnt;

    // Slot storage.
    logic [SLOTS-1:0]  r_slot_vld;
    logic [MARK_W-1:0] r_mark_mem [SLOTS];
    logic [KEY_W-1:0]  r_key_mem  [SLOTS];
    logic [DATA_W-1:0] r_data_mem [SLOTS];
    logic              r_rd_vld;
    logic [MARK_W-1:0] r_rd_mark;
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_data;

    // Probe outcome.
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_at;
    logic [DATA_W-1:0] r_hit_data;
    logic              r_emp;
    logic [IDX_W-1:0]  r_emp_at;
    logic              r_tomb;
    logic [IDX_W-1:0]  r_tomb_at;

    // Result registers.
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [DATA_W-1:0]   r_dout;

    // Eight steps of shift-in-a-bit then conditional subtract keep the
    // running residue below SLOTS.
    always_comb begin
        logic [IDX_W:0] h;
        h     = '0;
        n_res = r_res;
        for (int i = 0; i < HASH_BITS; i++) begin
            h = {n_res, r_kshift[KEY_W-1-i]};
            if (h >= SLOTS_X) h = h - SLOTS_X;
            n_res = h[IDX_W-1:0];
        end
    end

    logic e_empty;
    logic e_used;
    logic e_hit;
    logic e_tomb;
    logic e_stop;

    assign e_empty = !r_rd_vld;
    assign e_used  = r_rd_vld && (r_rd_mark == MARK_USED);
    assign e_hit   = e_used && (r_rd_key == r_key);
    assign e_tomb  = r_rd_vld && !e_used;
    assign e_stop  = e_empty || e_hit || (r_cnt == LAST_CNT);

    assign o_sts.hash_last  = (r_hcnt == HCNT_W'(HASH_STEPS - 1));
    assign o_sts.probe_done = r_rd_ok && e_stop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_key    <= i_key;
            r_din    <= i_data_in;
            r_kshift <= i_key;
            r_res    <= '0;
            r_hcnt   <= '0;
        end
        if (i_cmd.hash_step) begin
            r_kshift <= r_kshift << HASH_BITS;
            r_res    <= n_res;
            r_hcnt   <= r_hcnt + 1'b1;
            r_ptr    <= n_res;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_emp    <= 1'b0;
            r_tomb   <= 1'b0;
        end
        if (i_cmd.probe_step) begin
            r_ptr    <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            r_rd_pos <= r_ptr;
        end
        if (i_cmd.probe_step && r_rd_ok) begin
            r_cnt <= r_cnt + 1'b1;
        end
        // The slot that closes a full lap can still be the first tombstone.
        if (r_rd_ok && !i_cmd.commit && e_tomb && !r_tomb) begin
            r_tomb    <= 1'b1;
            r_tomb_at <= r_rd_pos;
        end
        if (r_rd_ok && e_stop && !i_cmd.commit) begin
            r_hit      <= e_hit;
            r_hit_at   <= r_rd_pos;
            r_hit_data <= r_rd_data;
            r_emp      <= e_empty;
            r_emp_at   <= r_rd_pos;
        end
    end

    // Pending read marker: set once the first slot read has been issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_cmd.hash_step || i_cmd.commit) begin
            r_rd_ok <= 1'b0;
        end else if (i_cmd.probe_step) begin
            r_rd_ok <= 1'b1;
        end
    end

    // Write decode for the commit cycle.
    logic              ins_new;
    logic              we_data;
    logic              we_mark;
    logic [IDX_W-1:0]  wr_at;
    logic [MARK_W-1:0] wr_mark;

    always_comb begin
        ins_new = (r_op == CMD_INSERT) && !r_hit && (r_tomb || r_emp);
        we_data = i_cmd.commit && (r_op == CMD_INSERT) && (r_hit || r_tomb || r_emp);
        we_mark = i_cmd.commit && (ins_new || ((r_op == CMD_REMOVE) && r_hit));
        wr_mark = (r_op == CMD_REMOVE) ? MARK_TOMB : MARK_USED;
        if (r_hit) begin
            wr_at = r_hit_at;
        end else if (r_tomb) begin
            wr_at = r_tomb_at;
        end else begin
            wr_at = r_emp_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (we_mark) begin
            r_slot_vld[wr_at] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_mark) begin
            r_mark_mem[wr_at] <= wr_mark;
        end
        if (i_cmd.commit && ins_new) begin
            r_key_mem[wr_at] <= r_key;
        end
        if (we_data) begin
            r_data_mem[wr_at] <= r_din;
        end
        r_rd_vld  <= r_slot_vld[r_ptr];
        r_rd_mark <= r_mark_mem[r_ptr];
        r_rd_key  <= r_key_mem[r_ptr];
        r_rd_data <= r_data_mem[r_ptr];
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (r_op)
                CMD_INSERT: begin
                    r_status <= (r_hit || r_tomb || r_emp) ? ST_OK : ST_FULL;
                    r_dout   <= '0;
                end
                CMD_SEARCH: begin
                    r_status <= r_hit ? ST_OK : ST_MISSING;
                    r_dout   <= r_hit ? r_hit_data : '0;
                end
                CMD_REMOVE: begin
                    r_status <= r_hit ? ST_OK : ST_MISSING;
                    r_dout   <= '0;
                end
                default: begin
                    r_status <= ST_MISSING;
                    r_dout   <= '0;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_data_out = r_dout;

endmodule
